// ===== src/pwcr_pkg.sv =====
// Types, codes and fixed widths shared by the pulse-width capture ring.
package pwcr_pkg;

  localparam int TIME_W     = 32;
  localparam int DUR_W      = 16;
  localparam int CNT_W      = 9;
  localparam int IDX_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [DUR_W-1:0]  DUR_MAX      = 16'hFFFF;
  localparam logic [TIME_W-1:0] DUR_MAX_WIDE = 32'h0000_FFFF;

  typedef enum logic [2:0] {
    FUNC_EDGE    = 3'd0,
    FUNC_POP     = 3'd1,
    FUNC_READ_AT = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_PAUSE   = 3'd4,
    FUNC_RESUME  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_LEVEL = 2'd0,
    REG_CAPACITY   = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]              func;
    logic [TIME_W-1:0]       edge_time_us;
    logic                    pin_level;
    logic signed [IDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic [DUR_W-1:0] value;
    err_e             error;
    logic [CNT_W-1:0] count;
    logic             is_paused;
  } result_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage

// ===== src/pwcr_if.sv =====
// Handshake channels of the capture ring: events in, results out, register writes.
interface pwcr_evt_if import pwcr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              func;
  logic [TIME_W-1:0]       edge_time_us;
  logic                    pin_level;
  logic signed [IDX_W-1:0] read_index;

  modport source (output valid, func, edge_time_us, pin_level, read_index, input ready);
  modport sink   (input valid, func, edge_time_us, pin_level, read_index, output ready);
endinterface

interface pwcr_res_if import pwcr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] value;
  logic [1:0]       error;
  logic [CNT_W-1:0] count;
  logic             is_paused;

  modport source (output valid, value, error, count, is_paused, input ready);
  modport sink   (input valid, value, error, count, is_paused, output ready);
endinterface

interface pwcr_cfg_if import pwcr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pwcr_ram.sv =====
// Single-port duration store with registered read data.
module pwcr_ram import pwcr_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk_i,
  input  ram_ctl_t         ctl_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [DUR_W-1:0] wdata_i,
  output logic [DUR_W-1:0] rdata_o
);

  logic [DUR_W-1:0] mem [DEPTH];
  logic [DUR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pwcr_ctrl.sv =====
// Sequencer and ring pointers: decodes each event, drives the store, builds the result.
module pwcr_ctrl import pwcr_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_wr_t          cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  item_t            item_i,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output result_t          res_o,
  output ram_ctl_t         ram_ctl_o,
  output logic [AW-1:0]    ram_addr_o,
  output logic [DUR_W-1:0] ram_wdata_o,
  input  logic [DUR_W-1:0] ram_rdata_i
);

  localparam int SW = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_e state_q, state_d;
  logic   exec_en;

  item_t               item_q;
  logic                idle_q, idle_d;
  logic [CNT_W-1:0]    cap_q, cap_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [TIME_W-1:0]   last_q, last_d;
  logic                await_q, await_d;
  logic                paused_q, paused_d;
  logic                rd_ok_q, rd_ok_d;
  err_e                err_q, err_d;
  logic [CNT_W-1:0]    cnt_q;
  logic                res_paused_q;

  func_e               func;
  logic [SW-1:0]       head_ext;
  logic [SW-1:0]       cap_ext;
  logic [SW-1:0]       wsum, waddr, rsum, raddr;
  logic [SW-1:0]       head_inc;
  logic [TIME_W-1:0]   diff;
  logic [DUR_W-1:0]    dur;
  logic signed [IDX_W:0] idx_ext, fill_s, pos;
  logic                pos_bad;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    exec_en     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        exec_en = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          in_ready_o = 1'b1;
          state_d    = in_valid_i ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // address arithmetic; every sum stays below twice the capacity
  assign func     = func_e'(item_q.func);
  assign head_ext = SW'(head_q);
  assign cap_ext  = SW'(cap_q);
  assign wsum     = head_ext + SW'(fill_q);
  assign waddr    = (wsum >= cap_ext) ? wsum - cap_ext : wsum;
  assign head_inc = (head_ext + SW'(1) >= cap_ext) ? '0 : head_ext + SW'(1);

  assign diff = item_q.edge_time_us - last_q;
  assign dur  = (diff >= DUR_MAX_WIDE) ? DUR_MAX : diff[DUR_W-1:0];

  assign idx_ext = {item_q.read_index[IDX_W-1], item_q.read_index};
  assign fill_s  = $signed({{(IDX_W+1-CNT_W){1'b0}}, fill_q});
  assign pos     = idx_ext[IDX_W] ? idx_ext + fill_s : idx_ext;
  assign pos_bad = pos[IDX_W] || (pos >= fill_s);
  assign rsum    = head_ext + SW'(pos[CNT_W-1:0]);
  assign raddr   = (rsum >= cap_ext) ? rsum - cap_ext : rsum;

  always_comb begin
    idle_d      = idle_q;
    cap_d       = cap_q;
    head_d      = head_q;
    fill_d      = fill_q;
    last_d      = last_q;
    await_d     = await_q;
    paused_d    = paused_q;
    rd_ok_d     = 1'b0;
    err_d       = ERR_OK;
    ram_ctl_o   = '0;
    ram_addr_o  = head_q;
    ram_wdata_o = dur;

    if (exec_en) begin
      case (func)
        FUNC_EDGE: begin
          if (!paused_q) begin
            if (await_q) begin
              if (item_q.pin_level != idle_q) begin
                await_d = 1'b0;
              end
            end else begin
              ram_ctl_o.we = 1'b1;
              ram_addr_o   = waddr[AW-1:0];
              if (fill_q < cap_q) begin
                fill_d = fill_q + CNT_W'(1);
              end else begin
                head_d = head_inc[AW-1:0];
              end
            end
            last_d = item_q.edge_time_us;
          end
        end
        FUNC_POP: begin
          if (fill_q == '0) begin
            err_d = ERR_EMPTY;
          end else begin
            ram_ctl_o.re = 1'b1;
            rd_ok_d      = 1'b1;
            head_d       = head_inc[AW-1:0];
            fill_d       = fill_q - CNT_W'(1);
          end
        end
        FUNC_READ_AT: begin
          if (pos_bad) begin
            err_d = ERR_RANGE;
          end else begin
            ram_ctl_o.re = 1'b1;
            ram_addr_o   = raddr[AW-1:0];
            rd_ok_d      = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          head_d = '0;
          fill_d = '0;
        end
        FUNC_PAUSE: begin
          paused_d = 1'b1;
        end
        FUNC_RESUME: begin
          await_d  = 1'b1;
          paused_d = 1'b0;
          last_d   = '0;
        end
        default: begin
        end
      endcase
    end

    // register writes are to arrive only while no event is in flight; not enforced here
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_IDLE_LEVEL: begin
          idle_d = cfg_i.data[0];
        end
        REG_CAPACITY: begin
          if (cfg_i.data == '0) begin
            cap_d = CNT_W'(1);
          end else if (cfg_i.data > DEPTH_C) begin
            cap_d = DEPTH_C;
          end else begin
            cap_d = cfg_i.data;
          end
          head_d = '0;
          fill_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q   <= 1'b0;
      cap_q    <= DEPTH_C;
      head_q   <= '0;
      fill_q   <= '0;
      last_q   <= '0;
      await_q  <= 1'b1;
      paused_q <= 1'b0;
      rd_ok_q  <= 1'b0;
      err_q    <= ERR_OK;
    end else begin
      idle_q   <= idle_d;
      cap_q    <= cap_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      last_q   <= last_d;
      await_q  <= await_d;
      paused_q <= paused_d;
      if (exec_en) begin
        rd_ok_q <= rd_ok_d;
        err_q   <= err_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
    if (exec_en) begin
      cnt_q        <= fill_d;
      res_paused_q <= paused_d;
    end
  end

  assign res_o.value     = rd_ok_q ? ram_rdata_i : '0;
  assign res_o.error     = err_q;
  assign res_o.count     = cnt_q;
  assign res_o.is_paused = res_paused_q;

endmodule

// ===== src/pulse_width_capture_ring.sv =====
// A result passes through the execute and respond states into the output register,
// where it is offered. The sequencer runs decode and store access in the execute state
// and collects the registered read in the respond state, where the next event is taken.
// Reset clears pointers, fill, last time and pause state, re-arms the edge wait, clears
// the output valid flag; the duration store is not cleared and needs no clearing pass.
// A finished result waits in the output register while the next event is taken.
module pulse_width_capture_ring import pwcr_pkg::*; #(
  parameter int MAX_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pwcr_cfg_if.sink  cfg_i,
  pwcr_evt_if.sink  evt_i,
  pwcr_res_if.source res_o
);

  // the capacity register cannot address beyond this
  localparam int DEPTH = (MAX_DEPTH < 511) ? MAX_DEPTH : 511;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_wr_t          cfg_wr;
  item_t            item;
  result_t          res, out_q;
  logic             out_valid_q;
  logic             res_valid, res_take;
  ram_ctl_t         ram_ctl;
  logic [AW-1:0]    ram_addr;
  logic [DUR_W-1:0] ram_wdata, ram_rdata;

  assign cfg_i.ready   = 1'b1;
  assign cfg_wr.valid  = cfg_i.valid;
  assign cfg_wr.index  = cfg_i.index;
  assign cfg_wr.data   = cfg_i.data;

  assign item.func         = evt_i.func;
  assign item.edge_time_us = evt_i.edge_time_us;
  assign item.pin_level    = evt_i.pin_level;
  assign item.read_index   = evt_i.read_index;

  assign res_take = res_valid && (!out_valid_q || res_o.ready);

  pwcr_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .in_valid_i  (evt_i.valid),
    .in_ready_o  (evt_i.ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .ram_ctl_o   (ram_ctl),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  pwcr_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.value     = out_q.value;
  assign res_o.error     = out_q.error;
  assign res_o.count     = out_q.count;
  assign res_o.is_paused = out_q.is_paused;

  // an event transfer is always followed by a busy cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.valid && evt_i.ready |=> !evt_i.ready)
    else $error("event taken during execute cycle");

  // a failed request never carries a duration
  a_err_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.error != ERR_OK |-> res.value == '0)
    else $error("error result with nonzero value");

  // empty pop only when the ring holds nothing
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.error == ERR_EMPTY |-> res.count == '0)
    else $error("empty error with nonzero count");

  // a collected result is presented on the next cycle
  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> out_valid_q)
    else $error("collected result not presented");

endmodule
